FILE: hw/rtl/bdar_pkg.sv
package bdar_pkg;

    localparam int NUM_BUTTONS     = 5;
    localparam int NUM_DIRECTIONAL = 4;
    localparam int TIMER_WIDTH     = 12;
    localparam int DEB_WIDTH       = 8;
    localparam int MASK_WIDTH      = 5;
    localparam int CFG_DATA_WIDTH  = 12;
    localparam int CFG_IDX_WIDTH   = 3;
    localparam int BTN_WIDTH       = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DEBOUNCE_TICKS     = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_REPEAT_FIRST_DELAY = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_REPEAT_PERIOD      = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_ACCEPT_MASK        = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_REPEAT_ENABLE      = 3'd4;

    // reset values of the configuration registers
    localparam logic [DEB_WIDTH-1:0]   RST_DEBOUNCE_TICKS     = 8'd25;
    localparam logic [TIMER_WIDTH-1:0] RST_REPEAT_FIRST_DELAY = 12'd350;
    localparam logic [TIMER_WIDTH-1:0] RST_REPEAT_PERIOD      = 12'd100;
    localparam logic [MASK_WIDTH-1:0]  RST_ACCEPT_MASK        = 5'd31;
    localparam logic                   RST_REPEAT_ENABLE      = 1'b1;

    // event codes
    localparam logic [BTN_WIDTH-1:0] KEY_NONE   = 3'd0;
    localparam logic [BTN_WIDTH-1:0] KEY_UP     = 3'd1;
    localparam logic [BTN_WIDTH-1:0] KEY_DOWN   = 3'd2;
    localparam logic [BTN_WIDTH-1:0] KEY_LEFT   = 3'd3;
    localparam logic [BTN_WIDTH-1:0] KEY_RIGHT  = 3'd4;
    localparam logic [BTN_WIDTH-1:0] KEY_SELECT = 3'd5;

    typedef struct packed {
        logic accept;   // lane sees an accepted level change
        logic press;    // that change is a press
    } t_lane_stat;

    typedef struct packed {
        logic [BTN_WIDTH-1:0] event_button;
        logic                 is_repeat;
    } t_result;

    typedef struct packed {
        logic [DEB_WIDTH-1:0]   debounce_ticks;
        logic [TIMER_WIDTH-1:0] repeat_first_delay;
        logic [TIMER_WIDTH-1:0] repeat_period;
        logic [MASK_WIDTH-1:0]  accept_mask;
        logic                   repeat_enable;
    } t_cfg;

endpackage

FILE: hw/rtl/bdar_in_if.sv
interface bdar_in_if;
    import bdar_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [MASK_WIDTH-1:0] raw_levels;

    modport source (output valid, output raw_levels, input ready);
    modport sink (input valid, input raw_levels, output ready);
endinterface

FILE: hw/rtl/bdar_out_if.sv
interface bdar_out_if;
    import bdar_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [BTN_WIDTH-1:0] event_button;
    logic                 is_repeat;

    modport source (output valid, output event_button, output is_repeat, input ready);
    modport sink (input valid, input event_button, input is_repeat, output ready);
endinterface

FILE: hw/rtl/button_debounce_autorepeat.sv
// Debouncer for five active-low buttons with typematic auto-repeat. Each input
// transaction is one millisecond tick carrying the raw pin levels; each tick gives
// exactly one output transaction (event_button 0 when nothing is reported). One
// lane per button holds its debounced level and a saturating tick counter; a merge
// stage picks the first accepted press, freezes the lanes after it for that tick,
// applies the report mask and runs the repeat timer for a held direction. A tick
// is taken every clock cycle while the queue has a free entry, and its result is
// registered in a two-entry output queue, so input keeps flowing while one result
// waits; the rate is one tick per cycle, set by the lane and merge update, until the
// queue fills. Write the configuration registers (index 0 debounce, 1 first delay,
// 2 period, 3 mask, 4 repeat enable) only while no tick is pending in the block.
module button_debounce_autorepeat
    import bdar_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_WIDTH-1:0] i_cfg_data,
    bdar_in_if.sink                   i_in,
    bdar_out_if.source                o_out
);

    t_cfg                   r_cfg;
    t_lane_stat             lane_stat [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] apply;
    logic [NUM_BUTTONS-1:0] pressed_now;
    t_result                result;
    logic                   tick;
    logic                   pop;

    // two-entry output queue
    t_result    r_q [2];
    logic       r_head;
    logic [1:0] r_count;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks     <= RST_DEBOUNCE_TICKS;
            r_cfg.repeat_first_delay <= RST_REPEAT_FIRST_DELAY;
            r_cfg.repeat_period      <= RST_REPEAT_PERIOD;
            r_cfg.accept_mask        <= RST_ACCEPT_MASK;
            r_cfg.repeat_enable      <= RST_REPEAT_ENABLE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE_TICKS: begin
                    r_cfg.debounce_ticks <= i_cfg_data[DEB_WIDTH-1:0];
                end
                CFG_REPEAT_FIRST_DELAY: begin
                    r_cfg.repeat_first_delay <= i_cfg_data[TIMER_WIDTH-1:0];
                end
                CFG_REPEAT_PERIOD: begin
                    r_cfg.repeat_period <= i_cfg_data[TIMER_WIDTH-1:0];
                end
                CFG_ACCEPT_MASK: begin
                    r_cfg.accept_mask <= i_cfg_data[MASK_WIDTH-1:0];
                end
                CFG_REPEAT_ENABLE: begin
                    r_cfg.repeat_enable <= i_cfg_data[0];
                end
                default: begin
                    // unused index: drop the write
                end
            endcase
        end
    end

    // hold the tick off only when both queue entries are occupied
    assign i_in.ready  = (r_count != 2'd2);
    assign tick        = i_in.valid & i_in.ready;
    assign pop         = o_out.valid & o_out.ready;
    assign pressed_now = ~i_in.raw_levels[NUM_BUTTONS-1:0];

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        bdar_lane u_lane (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_tick           (tick),
            .i_pressed        (pressed_now[g]),
            .i_debounce_ticks (r_cfg.debounce_ticks),
            .i_apply          (apply[g]),
            .o_stat           (lane_stat[g])
        );
    end

    bdar_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick    (tick),
        .i_pressed (pressed_now),
        .i_stat    (lane_stat),
        .i_cfg     (r_cfg),
        .o_apply   (apply),
        .o_result  (result)
    );

    // queue payload: write behind the occupied entries
    always_ff @(posedge i_clk) begin
        if (tick) begin
            r_q[r_head ^ (r_count != 2'd0)] <= result;
        end
    end

    // queue control: advance the head on every completed output transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (pop) begin
                r_head <= ~r_head;
            end
            case ({tick, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_out.valid        = (r_count != 2'd0);
    assign o_out.event_button = r_q[r_head].event_button;
    assign o_out.is_repeat    = r_q[r_head].is_repeat;

endmodule

FILE: hw/rtl/bdar_lane.sv
module bdar_lane
    import bdar_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tick,
    input  logic                 i_pressed,
    input  logic [DEB_WIDTH-1:0] i_debounce_ticks,
    input  logic                 i_apply,
    output t_lane_stat           o_stat
);

    logic [DEB_WIDTH-1:0] r_since;
    logic                 r_deb;
    logic [DEB_WIDTH-1:0] n_since;
    logic                 n_deb;
    logic [DEB_WIDTH-1:0] since_inc;
    logic                 accept;

    // saturate at the limit; a lowered limit leaves a larger count alone
    assign since_inc = (r_since < i_debounce_ticks) ? r_since + 1'b1 : r_since;
    assign accept    = (i_pressed ^ r_deb) && (since_inc >= i_debounce_ticks);

    assign o_stat.accept = accept;
    assign o_stat.press  = accept & i_pressed;

    always_comb begin
        if (accept && i_apply) begin
            n_since = '0;
            n_deb   = ~r_deb;
        end else begin
            n_since = since_inc;
            n_deb   = r_deb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since <= '0;
            r_deb   <= 1'b0;
        end else if (i_tick) begin
            r_since <= n_since;
            r_deb   <= n_deb;
        end
    end

endmodule

FILE: hw/rtl/bdar_merge.sv
module bdar_merge
    import bdar_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_tick,
    input  logic [NUM_BUTTONS-1:0] i_pressed,
    input  t_lane_stat             i_stat [NUM_BUTTONS],
    input  t_cfg                   i_cfg,
    output logic [NUM_BUTTONS-1:0] o_apply,
    output t_result                o_result
);

    logic [BTN_WIDTH-1:0]   r_held;
    logic [TIMER_WIDTH-1:0] r_countdown;
    logic [BTN_WIDTH-1:0]   n_held;
    logic [TIMER_WIDTH-1:0] n_countdown;
    logic [BTN_WIDTH-1:0]   press_btn;
    logic                   found;
    logic                   still;
    logic                   masked;
    logic [TIMER_WIDTH-1:0] cd_dec;

    always_comb begin
        // lanes past the first accepted press are frozen this tick
        found     = 1'b0;
        press_btn = KEY_NONE;
        masked    = 1'b0;
        still     = 1'b0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            o_apply[i] = ~found;
            if (!found && i_stat[i].press) begin
                found     = 1'b1;
                press_btn = BTN_WIDTH'(i + 1);
                masked    = i_cfg.accept_mask[i];
            end
            if (r_held == BTN_WIDTH'(i + 1)) begin
                still = i_pressed[i];
            end
        end

        cd_dec      = (r_countdown != '0) ? r_countdown - 1'b1 : r_countdown;
        n_held      = r_held;
        n_countdown = r_countdown;
        o_result.event_button = KEY_NONE;
        o_result.is_repeat    = 1'b0;

        if (found && masked) begin
            o_result.event_button = press_btn;
            n_held = (press_btn <= BTN_WIDTH'(NUM_DIRECTIONAL) && i_cfg.repeat_enable)
                     ? press_btn : KEY_NONE;
            n_countdown = i_cfg.repeat_first_delay;
        end else if (r_held != KEY_NONE) begin
            if (!still || !i_cfg.repeat_enable) begin
                n_held = KEY_NONE;
            end else if (cd_dec == '0) begin
                o_result.event_button = r_held;
                o_result.is_repeat    = 1'b1;
                n_countdown           = i_cfg.repeat_period;
            end else begin
                n_countdown = cd_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= KEY_NONE;
            r_countdown <= '0;
        end else if (i_tick) begin
            r_held      <= n_held;
            r_countdown <= n_countdown;
        end
    end

endmodule

FILE: bench/button_debounce_autorepeat_test.sv
`timescale 1ns / 100ps

module button_debounce_autorepeat_test;
    import bdar_pkg::*;

    // Give up well past the slowest legal run: about 900 ticks, each with the longest
    // sender gap and receiver stall, plus one long hold-off.
    localparam int LIMIT_CYCLES   = 200000;
    localparam int LONG_HOLD      = 60;
    localparam int REPORT_LIMIT   = 10;
    localparam int NUM_DIRECTED   = 23;
    localparam int RANDOM_PHASES  = 10;

    // Directed script, first tick in the top slice. It walks the scan order
    // with every pin low at once, holds up and right long enough to repeat,
    // slides from up to down in one tick, and presses select.
    localparam logic [MASK_WIDTH*NUM_DIRECTED-1:0] DIRECTED_SCRIPT = {
        5'h1f, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1f,
        5'h1e, 5'h1e, 5'h1e, 5'h1e, 5'h1e, 5'h1d, 5'h1d, 5'h1d,
        5'h0f, 5'h1f, 5'h17, 5'h17, 5'h17, 5'h10, 5'h1f
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                      cfg_we;
    logic [CFG_IDX_WIDTH-1:0]  cfg_idx;
    logic [CFG_DATA_WIDTH-1:0] cfg_data;

    bdar_in_if  tick_if ();
    bdar_out_if event_if ();

    button_debounce_autorepeat dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (tick_if),
        .o_out      (event_if)
    );

    always #1 i_clk = ~i_clk;

    // Pending ticks for the driver and events the keypad model still owes.
    logic [MASK_WIDTH-1:0] tick_queue[$];
    t_result               expected_events[$];

    // Knobs set by the stimulus process at the falling edge.
    logic send_hold      = 1'b0;
    logic long_hold_req  = 1'b0;
    logic calm           = 1'b0;

    int mismatch_count = 0;
    int cycle_count    = 0;

    // Keypad model: configuration copy and per-button state.
    t_cfg                   shadow_cfg;
    logic [NUM_BUTTONS-1:0] deb_pressed;
    logic [DEB_WIDTH-1:0]   settle_cnt[NUM_BUTTONS];
    logic [BTN_WIDTH-1:0]   held_dir;
    logic [TIMER_WIDTH-1:0] rpt_cnt;

    // Advance the keypad model by one millisecond tick and return its event.
    function automatic t_result advance_keypad(input logic [MASK_WIDTH-1:0] raw);
        logic [NUM_BUTTONS-1:0] now_pressed;
        logic [BTN_WIDTH-1:0]   hit;
        logic                   scan_done;
        t_result                res;
        now_pressed = ~raw[NUM_BUTTONS-1:0];
        hit = KEY_NONE;
        scan_done = 1'b0;
        res.event_button = KEY_NONE;
        res.is_repeat = 1'b0;

        // Age every button first; counters stop at the debounce limit.
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (settle_cnt[b] < shadow_cfg.debounce_ticks)
                settle_cnt[b] = settle_cnt[b] + 1'b1;
        end

        // Scan upward; a settled release keeps going, a settled press stops.
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (!scan_done && now_pressed[b] != deb_pressed[b] &&
                settle_cnt[b] >= shadow_cfg.debounce_ticks) begin
                settle_cnt[b] = '0;
                deb_pressed[b] = now_pressed[b];
                if (now_pressed[b]) begin
                    hit = BTN_WIDTH'(b + 1);
                    scan_done = 1'b1;
                end
            end
        end

        if (hit != KEY_NONE && shadow_cfg.accept_mask[hit - 1]) begin
            res.event_button = hit;
            held_dir = (hit <= NUM_DIRECTIONAL && shadow_cfg.repeat_enable) ? hit : KEY_NONE;
            rpt_cnt = shadow_cfg.repeat_first_delay;
        end else if (held_dir != KEY_NONE) begin
            // The raw pin, not the debounced level, cancels the repeat.
            if (!now_pressed[held_dir - 1] || !shadow_cfg.repeat_enable) begin
                held_dir = KEY_NONE;
            end else begin
                if (rpt_cnt != '0)
                    rpt_cnt = rpt_cnt - 1'b1;
                if (rpt_cnt == '0) begin
                    res.event_button = held_dir;
                    res.is_repeat = 1'b1;
                    rpt_cnt = shadow_cfg.repeat_period;
                end
            end
        end
        return res;
    endfunction

    // Driver: offer the next tick whenever the slot is free, hold it while the
    // block stalls, and insert random gaps between ticks.
    int send_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_if.valid <= 1'b0;
            tick_if.raw_levels <= '1;
            send_gap <= 0;
        end else if (!tick_if.valid || tick_if.ready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                tick_if.valid <= 1'b0;
            end else if (tick_queue.size() != 0 && !send_hold) begin
                tick_if.valid <= 1'b1;
                tick_if.raw_levels <= tick_queue.pop_front();
                if (!calm && $urandom_range(0, 7) == 0)
                    send_gap <= $urandom_range(1, 14);
            end else begin
                tick_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off counted here so
    // the output queue fills and backs up into the tick input.
    int   recv_gap;
    int   hold_left;
    logic long_hold_done;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            event_if.ready <= 1'b0;
            recv_gap <= 0;
            hold_left <= 0;
            long_hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            event_if.ready <= 1'b0;
        end else if (long_hold_req && !long_hold_done) begin
            hold_left <= LONG_HOLD - 1;
            long_hold_done <= 1'b1;
            event_if.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            event_if.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(0, 13);
            event_if.ready <= 1'b0;
        end else begin
            event_if.ready <= 1'b1;
        end
    end

    // Scoreboard: predict on every accepted tick, then check every accepted
    // event against the oldest prediction. Predicting first covers any latency.
    always @(posedge i_clk) begin : scoreboard
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (tick_if.valid && tick_if.ready)
                expected_events.push_back(advance_keypad(tick_if.raw_levels));
            if (event_if.valid && event_if.ready) begin
                got.event_button = event_if.event_button;
                got.is_repeat = event_if.is_repeat;
                if (expected_events.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected event: button %0d repeat %0b",
                                 got.event_button, got.is_repeat);
                end else begin
                    want = expected_events.pop_front();
                    if (got.event_button !== want.event_button ||
                        got.is_repeat !== want.is_repeat) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("mismatch: want button %0d rep %0b, got %0d rep %0b",
                                     want.event_button, want.is_repeat,
                                     got.event_button, got.is_repeat);
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Write one register and mirror it into the model copy. Only called while
    // the block is idle, so the model can take the value at once.
    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        case (idx)
            CFG_DEBOUNCE_TICKS:     shadow_cfg.debounce_ticks = val[DEB_WIDTH-1:0];
            CFG_REPEAT_FIRST_DELAY: shadow_cfg.repeat_first_delay = val[TIMER_WIDTH-1:0];
            CFG_REPEAT_PERIOD:      shadow_cfg.repeat_period = val[TIMER_WIDTH-1:0];
            CFG_ACCEPT_MASK:        shadow_cfg.accept_mask = val[MASK_WIDTH-1:0];
            CFG_REPEAT_ENABLE:      shadow_cfg.repeat_enable = val[0];
            default: ;
        endcase
    endtask

    task automatic program_settings(input logic [DEB_WIDTH-1:0] deb,
                                    input logic [TIMER_WIDTH-1:0] first,
                                    input logic [TIMER_WIDTH-1:0] period,
                                    input logic [MASK_WIDTH-1:0] mask,
                                    input logic enable);
        write_reg(CFG_DEBOUNCE_TICKS, CFG_DATA_WIDTH'(deb));
        write_reg(CFG_REPEAT_FIRST_DELAY, first);
        write_reg(CFG_REPEAT_PERIOD, period);
        write_reg(CFG_ACCEPT_MASK, CFG_DATA_WIDTH'(mask));
        write_reg(CFG_REPEAT_ENABLE, CFG_DATA_WIDTH'(enable));
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Block until every queued tick is taken and every event has come back,
    // then let the registered output queue settle a little longer.
    task automatic wait_idle();
        while (tick_queue.size() != 0 || tick_if.valid || expected_events.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Queue button gestures: mostly one or two buttons held for a random
    // stretch, with contact bounce sprinkled in, some idle stretches and some
    // pure noise.
    task automatic queue_gestures(input int n);
        logic [MASK_WIDTH-1:0] lv;
        int run;
        while (n > 0) begin
            case ($urandom_range(0, 9))
                0:       lv = MASK_WIDTH'($urandom);
                1, 2:    lv = '1;
                3:       lv = ~((MASK_WIDTH'(1) << $urandom_range(0, 4)) |
                                (MASK_WIDTH'(1) << $urandom_range(0, 4)));
                default: lv = ~(MASK_WIDTH'(1) << $urandom_range(0, 4));
            endcase
            run = $urandom_range(1, 40);
            while (run > 0 && n > 0) begin
                if ($urandom_range(0, 15) == 0)
                    tick_queue.push_back(lv ^ (MASK_WIDTH'(1) << $urandom_range(0, 4)));
                else
                    tick_queue.push_back(lv);
                run--;
                n--;
            end
        end
    endtask

    initial begin
        logic [DEB_WIDTH-1:0]   deb;
        logic [TIMER_WIDTH-1:0] first;
        logic [TIMER_WIDTH-1:0] period;
        logic [MASK_WIDTH-1:0]  mask;
        logic                   enable;
        int                     n_ticks;

        // Hold every block input at a known value from time zero.
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_DEBOUNCE_TICKS;
        cfg_data = '0;
        tick_if.valid = 1'b0;
        tick_if.raw_levels = '1;
        event_if.ready = 1'b0;

        // Model reset state matches the block after reset.
        shadow_cfg.debounce_ticks = RST_DEBOUNCE_TICKS;
        shadow_cfg.repeat_first_delay = RST_REPEAT_FIRST_DELAY;
        shadow_cfg.repeat_period = RST_REPEAT_PERIOD;
        shadow_cfg.accept_mask = RST_ACCEPT_MASK;
        shadow_cfg.repeat_enable = RST_REPEAT_ENABLE;
        deb_pressed = '0;
        for (int b = 0; b < NUM_BUTTONS; b++)
            settle_cnt[b] = '0;
        held_dir = KEY_NONE;
        rpt_cnt = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed ticks with no debounce and a short repeat so every change
        // lands at once and repeats show up within the script.
        program_settings(8'd0, 12'd2, 12'd1, 5'h1f, 1'b1);
        for (int k = 0; k < NUM_DIRECTED; k++)
            tick_queue.push_back(DIRECTED_SCRIPT[MASK_WIDTH*(NUM_DIRECTED-1-k) +: MASK_WIDTH]);
        wait_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    // Top of every range: nothing settles in this short phase.
                    deb = 8'd255; first = 12'd4095; period = 12'd4095;
                    mask = 5'h1f; enable = 1'b1; n_ticks = 40;
                end
                1: begin
                    // Zero debounce, zero delay and zero period: repeat on the
                    // very next tick of a hold.
                    deb = 8'd0; first = 12'd0; period = 12'd0;
                    mask = 5'h1f; enable = 1'b1; n_ticks = 60;
                end
                2: begin
                    // Nothing may be reported and no repeat may arm.
                    deb = 8'd3; first = 12'd5; period = 12'd3;
                    mask = 5'h00; enable = 1'b0; n_ticks = 40;
                end
                default: begin
                    deb = ($urandom_range(0, 7) == 0) ? DEB_WIDTH'($urandom_range(6, 40))
                                                      : DEB_WIDTH'($urandom_range(0, 5));
                    first = TIMER_WIDTH'($urandom_range(0, 24));
                    period = TIMER_WIDTH'($urandom_range(0, 10));
                    mask = ($urandom_range(0, 2) == 0) ? MASK_WIDTH'($urandom) : 5'h1f;
                    enable = ($urandom_range(0, 3) != 0);
                    n_ticks = 100;
                end
            endcase
            program_settings(deb, first, period, mask, enable);

            // Drop all idling for the closing phase.
            if (phase == RANDOM_PHASES - 1)
                calm = 1'b1;
            queue_gestures(n_ticks);

            // Stall the receiver long enough to back up the tick input.
            if (phase == 4) begin
                repeat (10) @(negedge i_clk);
                long_hold_req = 1'b1;
            end

            // Pause the sender mid-phase until every event has come back.
            if (phase == 6) begin
                repeat (30) @(negedge i_clk);
                send_hold = 1'b1;
                while (tick_if.valid || expected_events.size() != 0)
                    @(negedge i_clk);
                repeat (5) @(negedge i_clk);
                send_hold = 1'b0;
            end

            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_events.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
